/* hw/rtl/qslp_pkg.sv */
// types, codes and character constants for the quoted string list parser
// no dependencies; imported by every module of the block
package qslp_pkg;

  localparam int MAX_RESULTS = 3;

  // character constants
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_QMARK  = 8'h3f;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_VT     = 8'h0b;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_N  = 8'h6e;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_V  = 8'h76;

  // error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_WANT_OPEN  = 3'd1;
  localparam logic [2:0] ERR_WANT_STR   = 3'd2;
  localparam logic [2:0] ERR_WANT_SEP   = 3'd3;
  localparam logic [2:0] ERR_WANT_CLOSE = 3'd4;
  localparam logic [2:0] ERR_BAD_STATE  = 3'd5;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_OPENED  = 3'd1,
    PH_WANTSTR = 3'd2,
    PH_WANTSEP = 3'd3,
    PH_INSTR   = 3'd4,
    PH_ESCAPE  = 3'd5,
    PH_EMPTY   = 3'd6,
    PH_ERROR   = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_CHAR     = 2'd0,
    KIND_STR_END  = 2'd1,
    KIND_ERROR    = 2'd2,
    KIND_TEXT_END = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       final_byte;
  } in_word_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] char_out;
    logic [2:0] error_code;
    logic       open_dropped;
    logic       run_last;
  } out_word_t;

  // all results caused by one input byte
  typedef struct packed {
    logic [1:0]                  n;
    out_word_t [MAX_RESULTS-1:0] res;
  } job_t;

  // front to queue
  typedef struct packed {
    logic wr;
    job_t job;
  } q_wr_t;

  // queue head seen by the back end
  typedef struct packed {
    logic empty;
    job_t job;
  } q_head_t;

endpackage

/* hw/rtl/quoted_string_list_parser_unit.sv */
// top level of the quoted string list parser: front end, job queue, back end
// depends on qslp_pkg, qslp_front, qslp_fifo, qslp_back
//
// usage
//   input channel: one text byte per word on in_word (byte_in, final_byte);
//     a word is taken at a clock edge with push high and full low
//   result channel: the oldest result word sits on out_word while empty is
//     low; it is taken at a clock edge with pop high and empty low
//   each byte gives zero to three result words; run_last marks the last one
//     of a byte, and a byte flagged final always ends with an end-of-text word
//   path: a byte is parsed and its job written into the queue at the edge that
//     takes it; the job is loaded into the back end at a later edge, once the
//     back end holds no word or its last word of the current job is popped
//   throughput: one byte per cycle into the front end while full is low and one
//     result word per cycle out of the back end while pop is high; bytes with more
//     than one result drain at one word per cycle, so a run of them backs up the job queue
//   stalls: with pop low the back end holds its word and the job queue
//     (QUEUE_DEPTH jobs) fills; full rises once it holds QUEUE_DEPTH jobs
//   reset: parser back at expect-opening-bracket, queue and output empty
module quoted_string_list_parser_unit
  import qslp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_word_t  in_word,
  input  logic      pop,
  output logic      empty,
  output out_word_t out_word
);

  // byte accepted this edge
  logic    accept;
  // front end job write into the queue
  q_wr_t   q_wr;
  // queue head and read strobe from the back end
  q_head_t head;
  logic    rd;

  assign accept = push && !full;

  // parse state machine, one byte per cycle while the job queue is not full
  qslp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_word (in_word),
    .q_wr    (q_wr)
  );

  // decouples byte intake from result drain
  qslp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .q_wr  (q_wr),
    .rd    (rd),
    .full  (full),
    .head  (head)
  );

  // result serializer and output register
  qslp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .rd       (rd),
    .pop      (pop),
    .empty    (empty),
    .out_word (out_word)
  );

endmodule

/* hw/rtl/qslp_front.sv */
// front end: parse state machine, turns each accepted byte into a job of results
// depends on qslp_pkg
module qslp_front
  import qslp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_word_t in_word,
  output q_wr_t    q_wr
);

  phase_t phase_r, phase_nxt;
  logic   qd_r, qd_nxt;

  logic [7:0]                  c;
  logic [7:0]                  quote_ch;
  logic [7:0]                  esc_ch;
  logic                        esc_known;
  logic                        is_quote;
  logic [1:0]                  cnt;
  out_word_t [MAX_RESULTS-1:0] res;

  function automatic logic blank_byte(input logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_LF ||
           b == CH_VT || b == CH_FF || b == CH_CR;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      qd_r    <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      qd_r    <= qd_nxt;
    end
  end

  // escape decode
  always_comb begin
    esc_known = 1'b1;
    esc_ch    = c;
    unique case (c)
      CH_BSLASH, CH_DQUOTE, CH_SQUOTE, CH_QMARK: esc_ch = c;
      CH_LOW_T: esc_ch = CH_TAB;
      CH_LOW_N: esc_ch = CH_LF;
      CH_LOW_R: esc_ch = CH_CR;
      CH_LOW_A: esc_ch = CH_BEL;
      CH_LOW_B: esc_ch = CH_BS;
      CH_LOW_F: esc_ch = CH_FF;
      CH_LOW_V: esc_ch = CH_VT;
      default: begin
        esc_ch    = c;
        esc_known = 1'b0;
      end
    endcase
  end

  always_comb begin
    c         = in_word.byte_in;
    is_quote  = c == CH_SQUOTE || c == CH_DQUOTE;
    quote_ch  = qd_r ? CH_DQUOTE : CH_SQUOTE;
    phase_nxt = phase_r;
    qd_nxt    = qd_r;
    cnt       = 2'd0;
    res       = '0;
    unique case (phase_r)
      PH_START: begin
        if (c == CH_LBRACK) begin
          phase_nxt = PH_OPENED;
        end else begin
          res[cnt]  = '{KIND_ERROR, 8'd0, ERR_WANT_OPEN, 1'b0, 1'b0};
          cnt       = cnt + 2'd1;
          phase_nxt = PH_ERROR;
        end
      end
      PH_OPENED: begin
        if (!blank_byte(c)) begin
          if (is_quote) begin
            qd_nxt    = c == CH_DQUOTE;
            phase_nxt = PH_INSTR;
          end else if (c == CH_RBRACK) begin
            phase_nxt = PH_EMPTY;
          end else begin
            res[cnt]  = '{KIND_ERROR, 8'd0, ERR_WANT_CLOSE, 1'b0, 1'b0};
            cnt       = cnt + 2'd1;
            phase_nxt = PH_ERROR;
          end
        end
      end
      PH_WANTSTR: begin
        if (!blank_byte(c)) begin
          if (is_quote) begin
            qd_nxt    = c == CH_DQUOTE;
            phase_nxt = PH_INSTR;
          end else begin
            res[cnt]  = '{KIND_ERROR, 8'd0, ERR_WANT_STR, 1'b0, 1'b0};
            cnt       = cnt + 2'd1;
            phase_nxt = PH_ERROR;
          end
        end
      end
      PH_WANTSEP: begin
        if (!blank_byte(c)) begin
          if (c == CH_COMMA) begin
            phase_nxt = PH_WANTSTR;
          end else if (c == CH_RBRACK) begin
            phase_nxt = PH_START;
          end else begin
            res[cnt]  = '{KIND_ERROR, 8'd0, ERR_WANT_SEP, 1'b0, 1'b0};
            cnt       = cnt + 2'd1;
            phase_nxt = PH_ERROR;
          end
        end
      end
      PH_INSTR: begin
        if (c == CH_BSLASH) begin
          phase_nxt = PH_ESCAPE;
        end else if (c == quote_ch) begin
          res[cnt]  = '{KIND_STR_END, 8'd0, ERR_NONE, 1'b0, 1'b0};
          cnt       = cnt + 2'd1;
          phase_nxt = PH_WANTSEP;
        end else begin
          res[cnt] = '{KIND_CHAR, c, ERR_NONE, 1'b0, 1'b0};
          cnt      = cnt + 2'd1;
        end
      end
      PH_ESCAPE: begin
        if (!esc_known) begin
          res[cnt] = '{KIND_CHAR, CH_BSLASH, ERR_NONE, 1'b0, 1'b0};
          cnt      = cnt + 2'd1;
        end
        res[cnt]  = '{KIND_CHAR, esc_ch, ERR_NONE, 1'b0, 1'b0};
        cnt       = cnt + 2'd1;
        phase_nxt = PH_INSTR;
      end
      PH_EMPTY: begin
        res[cnt]  = '{KIND_ERROR, 8'd0, ERR_BAD_STATE, 1'b0, 1'b0};
        cnt       = cnt + 2'd1;
        phase_nxt = PH_ERROR;
      end
      PH_ERROR: begin
        phase_nxt = PH_ERROR;
      end
    endcase

    // end of text closes everything
    if (in_word.final_byte) begin
      res[cnt] = '{KIND_TEXT_END, 8'd0, ERR_NONE,
                   (phase_nxt == PH_INSTR || phase_nxt == PH_ESCAPE), 1'b0};
      cnt       = cnt + 2'd1;
      phase_nxt = PH_START;
      qd_nxt    = 1'b0;
    end

    for (int i = 0; i < MAX_RESULTS; i++) begin
      res[i].run_last = (cnt != 2'd0) && (2'(i) == cnt - 2'd1);
    end

    q_wr.wr      = accept && (cnt != 2'd0);
    q_wr.job.n   = cnt;
    q_wr.job.res = res;
  end

  a_final_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_word.final_byte |=> phase_r == PH_START && !qd_r)
    else $error("parser not back at start after final byte");

  a_final_ends_job: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_word.final_byte |->
      q_wr.wr && q_wr.job.res[q_wr.job.n - 2'd1].kind == KIND_TEXT_END)
    else $error("final byte job does not end with text end");

endmodule

/* hw/rtl/qslp_fifo.sv */
// short job queue between front and back end
// depends on qslp_pkg
module qslp_fifo
  import qslp_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst_n,
  input  q_wr_t   q_wr,
  input  logic    rd,
  output logic    full,
  output q_head_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_rd;

  assign full       = cnt_r == CW'(DEPTH);
  assign head.empty = cnt_r == '0;
  assign head.job   = mem_r[rd_ptr_r];
  assign do_rd      = rd && !head.empty;

  always_ff @(posedge clk) begin
    if (q_wr.wr) begin
      mem_r[wr_ptr_r] <= q_wr.job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (q_wr.wr) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (q_wr.wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!q_wr.wr && do_rd) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.wr |-> !full)
    else $error("job queue written while full");

endmodule

/* hw/rtl/qslp_back.sv */
// back end: walks the results of the head job out one word at a time
// depends on qslp_pkg
module qslp_back
  import qslp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  q_head_t   head,
  output logic      rd,
  input  logic      pop,
  output logic      empty,
  output out_word_t out_word
);

  job_t       cur_r, cur_nxt;
  logic       valid_r, valid_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       last_res;
  logic       take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_comb begin
    empty     = !valid_r;
    out_word  = cur_r.res[idx_r];
    last_res  = idx_r == cur_r.n - 2'd1;
    take      = !valid_r || (pop && last_res);
    rd        = take && !head.empty;
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    cur_nxt   = cur_r;
    if (valid_r && pop && !last_res) begin
      idx_nxt = idx_r + 2'd1;
    end else if (take) begin
      valid_nxt = !head.empty;
      cur_nxt   = head.job;
      idx_nxt   = 2'd0;
    end
  end

  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> idx_r < cur_r.n)
    else $error("result index beyond job");

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// testbench for quoted_string_list_parser_unit: list text bytes in, decoded result words out
// depends on qslp_pkg and the parser rtl; a built-in parser predicts each result word
module tb;
  import qslp_pkg::*;

  localparam int LONG_HOLD = 150;        // cycles the receiver holds off to back up the block
  localparam int DRAIN_CYCLES = 16;      // quiet time after the last expected word
  localparam longint TIMEOUT_NS = 2_000_000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      push = 1'b0;
  logic      full;
  in_word_t  in_word = '0;
  logic      pop = 1'b0;
  logic      empty;
  out_word_t out_word;

  // bytes waiting for the driver and result words waiting for the block
  in_word_t  pending[$];
  out_word_t expected_words[$];
  logic [7:0] text_buf[$];

  // parser state mirrored on the testbench side
  phase_t parse_st = PH_START;
  logic   dq_open = 1'b0;

  int  tx_idle_pct = 32;
  int  rx_idle_pct = 57;
  int  hold_cnt = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  logic in_taken = 1'b0;
  int  err_count = 0;

  logic [7:0] blank_set [6] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
  logic [7:0] esc_set [11] = '{CH_BSLASH, CH_DQUOTE, CH_SQUOTE, CH_QMARK, CH_LOW_T, CH_LOW_N,
                               CH_LOW_R, CH_LOW_A, CH_LOW_B, CH_LOW_F, CH_LOW_V};

  quoted_string_list_parser_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_word  (in_word),
    .pop      (pop),
    .empty    (empty),
    .out_word (out_word)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic out_word_t mk_word(kind_t k, logic [7:0] ch, logic [2:0] code,
                                        logic dropped);
    out_word_t w;
    w.kind = k;
    w.char_out = ch;
    w.error_code = code;
    w.open_dropped = dropped;
    w.run_last = 1'b0;
    return w;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT || c == CH_FF ||
           c == CH_CR;
  endfunction

  // append one byte to the text being built
  task automatic add_char(input logic [7:0] b);
    text_buf = {text_buf, b};
  endtask

  // advance the mirrored parser by one byte and queue the words it gives
  task automatic parse_byte(in_word_t w);
    out_word_t  batch[$];
    logic [7:0] c;
    logic [7:0] esc_ch;
    logic [7:0] close_q;
    logic       is_q;
    logic       known;
    c = w.byte_in;
    is_q = (c == CH_SQUOTE) || (c == CH_DQUOTE);
    case (parse_st)
      PH_START: begin
        if (c == CH_LBRACK) parse_st = PH_OPENED;
        else begin
          batch = {batch, mk_word(KIND_ERROR, 8'h00, ERR_WANT_OPEN, 1'b0)};
          parse_st = PH_ERROR;
        end
      end
      PH_OPENED: begin
        if (!is_blank(c)) begin
          if (is_q) begin
            dq_open = (c == CH_DQUOTE);
            parse_st = PH_INSTR;
          end else if (c == CH_RBRACK) begin
            parse_st = PH_EMPTY;
          end else begin
            batch = {batch, mk_word(KIND_ERROR, 8'h00, ERR_WANT_CLOSE, 1'b0)};
            parse_st = PH_ERROR;
          end
        end
      end
      PH_WANTSTR: begin
        if (!is_blank(c)) begin
          if (is_q) begin
            dq_open = (c == CH_DQUOTE);
            parse_st = PH_INSTR;
          end else begin
            batch = {batch, mk_word(KIND_ERROR, 8'h00, ERR_WANT_STR, 1'b0)};
            parse_st = PH_ERROR;
          end
        end
      end
      PH_WANTSEP: begin
        if (!is_blank(c)) begin
          if (c == CH_COMMA) parse_st = PH_WANTSTR;
          else if (c == CH_RBRACK) parse_st = PH_START;
          else begin
            batch = {batch, mk_word(KIND_ERROR, 8'h00, ERR_WANT_SEP, 1'b0)};
            parse_st = PH_ERROR;
          end
        end
      end
      PH_INSTR: begin
        // only the quote that opened the string closes it
        close_q = dq_open ? CH_DQUOTE : CH_SQUOTE;
        if (c == CH_BSLASH) parse_st = PH_ESCAPE;
        else if (c == close_q) begin
          batch = {batch, mk_word(KIND_STR_END, 8'h00, ERR_NONE, 1'b0)};
          parse_st = PH_WANTSEP;
        end else begin
          batch = {batch, mk_word(KIND_CHAR, c, ERR_NONE, 1'b0)};
        end
      end
      PH_ESCAPE: begin
        known = 1'b1;
        case (c)
          CH_BSLASH, CH_DQUOTE, CH_SQUOTE, CH_QMARK: esc_ch = c;
          CH_LOW_T: esc_ch = CH_TAB;
          CH_LOW_N: esc_ch = CH_LF;
          CH_LOW_R: esc_ch = CH_CR;
          CH_LOW_A: esc_ch = CH_BEL;
          CH_LOW_B: esc_ch = CH_BS;
          CH_LOW_F: esc_ch = CH_FF;
          CH_LOW_V: esc_ch = CH_VT;
          default: begin
            esc_ch = c;
            known = 1'b0;
          end
        endcase
        // unknown escape keeps its backslash
        if (!known) batch = {batch, mk_word(KIND_CHAR, CH_BSLASH, ERR_NONE, 1'b0)};
        batch = {batch, mk_word(KIND_CHAR, esc_ch, ERR_NONE, 1'b0)};
        parse_st = PH_INSTR;
      end
      PH_EMPTY: begin
        batch = {batch, mk_word(KIND_ERROR, 8'h00, ERR_BAD_STATE, 1'b0)};
        parse_st = PH_ERROR;
      end
      default: ;
    endcase
    if (w.final_byte) begin
      batch = {batch, mk_word(KIND_TEXT_END, 8'h00, ERR_NONE,
                              parse_st == PH_INSTR || parse_st == PH_ESCAPE)};
      parse_st = PH_START;
      dq_open = 1'b0;
    end
    if (batch.size() != 0) batch[batch.size() - 1].run_last = 1'b1;
    expected_words = {expected_words, batch};
  endtask

  task automatic put_word(input logic [7:0] b, input logic fin);
    in_word_t w;
    w.byte_in = b;
    w.final_byte = fin;
    pending = {pending, w};
  endtask

  task automatic add_blanks();
    repeat ($urandom_range(0, 2)) add_char(blank_set[$urandom_range(0, 5)]);
  endtask

  // queue whole texts, mostly well-formed lists with random strings, some corrupted,
  // cut short or pure noise; the last byte of each text is flagged final
  task automatic queue_texts(int n_bytes);
    int added;
    int pick;
    int cut;
    logic [7:0] qc;
    logic [7:0] b;
    added = 0;
    while (added < n_bytes) begin
      text_buf.delete();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 5)) add_char(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 2)) begin
          add_char(CH_LBRACK);
          add_blanks();
          if ($urandom_range(0, 7) == 0) begin
            // empty list; whatever follows is a bad-state error
            add_char(CH_RBRACK);
          end else begin
            for (int s = 0; s < $urandom_range(1, 3); s++) begin
              if (s != 0) begin
                add_char(CH_COMMA);
                add_blanks();
              end
              qc = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
              add_char(qc);
              repeat ($urandom_range(0, 6)) begin
                pick = $urandom_range(0, 99);
                if (pick < 15) begin
                  add_char(CH_BSLASH);
                  add_char(esc_set[$urandom_range(0, 10)]);
                end else if (pick < 25) begin
                  // mostly unknown escapes
                  add_char(CH_BSLASH);
                  add_char(8'($urandom_range(0, 255)));
                end else begin
                  b = (pick < 75) ? 8'($urandom_range(32, 126)) : 8'($urandom_range(0, 255));
                  // swap in the other quote so the string stays open
                  if (b == qc) b = (qc == CH_DQUOTE) ? CH_SQUOTE : CH_DQUOTE;
                  add_char(b);
                end
              end
              add_char(qc);
              add_blanks();
            end
            add_char(CH_RBRACK);
          end
          add_blanks();
        end
        // break the grammar at a random spot
        if ($urandom_range(0, 3) == 0)
          text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
        // end the text early, often inside a string or right after a backslash
        if ($urandom_range(0, 5) == 0) begin
          cut = $urandom_range(1, text_buf.size());
          while (text_buf.size() > cut) void'(text_buf.pop_back());
        end
      end
      foreach (text_buf[i]) put_word(text_buf[i], i == text_buf.size() - 1);
      added += text_buf.size();
    end
  endtask

  // driver: a new word goes out on the falling edge once the last one was taken
  always @(negedge clk) begin : send_p
    if (rst_n && !(push && !in_taken)) begin
      if (pending.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        in_word <= pending.pop_front();
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // long receiver hold-off, started once by the stimulus process
  always @(negedge clk) begin : hold_p
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt <= LONG_HOLD;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // receiver: random pop, forced low during the hold-off
  always @(negedge clk) begin
    if (!rst_n) pop <= 1'b0;
    else pop <= (hold_cnt == 0) && ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // monitor: predict on each taken byte, check each taken result word
  always @(posedge clk) begin : mon_p
    out_word_t exp_w;
    out_word_t got_w;
    logic      bad;
    in_taken = rst_n && push && !full;
    if (in_taken) parse_byte(in_word);
    if (rst_n && pop && !empty) begin
      got_w = out_word;
      if (expected_words.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("tb: result word with none expected: kind %0d char %02h err %0d",
                   got_w.kind, got_w.char_out, got_w.error_code);
      end else begin
        exp_w = expected_words.pop_front();
        bad = (got_w.kind !== exp_w.kind) || (got_w.char_out !== exp_w.char_out) ||
              (got_w.error_code !== exp_w.error_code) ||
              (got_w.open_dropped !== exp_w.open_dropped) ||
              (got_w.run_last !== exp_w.run_last);
        if (bad) begin
          err_count++;
          if (err_count <= 10)
            $display({"tb: mismatch, expected kind %0d char %02h err %0d dropped %0d ",
                      "last %0d, got kind %0d char %02h err %0d dropped %0d last %0d"},
                     exp_w.kind, exp_w.char_out, exp_w.error_code, exp_w.open_dropped,
                     exp_w.run_last, got_w.kind, got_w.char_out, got_w.error_code,
                     got_w.open_dropped, got_w.run_last);
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, whitespace, both quote kinds, other quote inside,
    // known and unknown escapes, comma and close
    put_word(CH_LBRACK, 1'b0);
    put_word(CH_SPACE, 1'b0);
    put_word(CH_DQUOTE, 1'b0);
    put_word(8'h00, 1'b0);
    put_word(8'hff, 1'b0);
    put_word(CH_SQUOTE, 1'b0);
    put_word(CH_BSLASH, 1'b0);
    put_word(CH_LOW_T, 1'b0);
    put_word(CH_BSLASH, 1'b0);
    put_word("q", 1'b0);
    put_word(CH_DQUOTE, 1'b0);
    put_word(CH_TAB, 1'b0);
    put_word(CH_COMMA, 1'b0);
    put_word(CH_SQUOTE, 1'b0);
    put_word(CH_BSLASH, 1'b0);
    put_word(CH_SQUOTE, 1'b0);
    put_word(CH_SQUOTE, 1'b0);
    put_word(CH_RBRACK, 1'b0);
    // empty list then any byte: bad state; final byte while in error: end word only
    put_word(CH_LBRACK, 1'b0);
    put_word(CH_RBRACK, 1'b0);
    put_word("x", 1'b0);
    put_word("y", 1'b1);
    // final byte on an unknown escape: three words, string reported dropped
    put_word(CH_LBRACK, 1'b0);
    put_word(CH_DQUOTE, 1'b0);
    put_word(CH_BSLASH, 1'b0);
    put_word("z", 1'b1);

    queue_texts(145);
    while (pending.size() != 0) @(posedge clk);

    tx_idle_pct = 57;
    rx_idle_pct = 32;
    queue_texts(145);
    while (pending.size() != 0) @(posedge clk);

    // no idling; partway in the receiver stops so the job queue fills and full rises
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    queue_texts(140);
    repeat (20) @(posedge clk);
    hold_req = 1'b1;
    while (pending.size() != 0 || push) @(posedge clk);

    while (expected_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_count == 0 && expected_words.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("tb: FAIL");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/qslp_pkg.sv
hw/rtl/qslp_front.sv
hw/rtl/qslp_fifo.sv
hw/rtl/qslp_back.sv
hw/rtl/quoted_string_list_parser_unit.sv
sim/tb.sv
